// ===== rtl/kclp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kclp_pkg
// Shared types and constants of the key click and long press detector.
// ----------------------------------------------------------------------------
package kclp_pkg;

    // Field widths
    localparam int KEY_W      = 3;
    localparam int CODE_W     = 3;
    localparam int CNT_W      = 8;
    localparam int TMR_W      = 16;
    localparam int SCAN_W     = 8;
    localparam int MASK_W     = 8;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Default key count
    localparam int NUM_KEYS_DEF = 8;

    // Register reset values
    localparam logic [SCAN_W-1:0] SCAN_RST   = 8'd10;
    localparam logic [TMR_W-1:0]  LONG_RST   = 16'd1000;
    localparam logic [TMR_W-1:0]  WINDOW_RST = 16'd300;
    localparam logic [MASK_W-1:0] MASK_RST   = 8'd0;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_INTERVAL = 4'd0,
        CFG_LONG_PRESS    = 4'd1,
        CFG_CLICK_WINDOW  = 4'd2,
        CFG_ACTIVE_MASK   = 4'd3
    } cfg_index_t;

    // Debouncer states
    typedef enum logic [1:0] {
        DB_RELEASED = 2'd0,
        DB_DOWN     = 2'd1,
        DB_PRESSED  = 2'd2,
        DB_UP       = 2'd3
    } db_state_t;

    // Gesture states
    typedef enum logic [2:0] {
        GS_IDLE    = 3'd0,
        GS_PRESSED = 3'd1,
        GS_WAIT    = 3'd2,
        GS_CONFIRM = 3'd3,
        GS_LONG    = 3'd4
    } gs_state_t;

    // Event codes
    typedef enum logic [CODE_W-1:0] {
        EV_CLICK    = 3'd0,
        EV_DOUBLE   = 3'd1,
        EV_MULTI    = 3'd2,
        EV_LONG     = 3'd3,
        EV_LONG_REL = 3'd4
    } evt_code_t;

    // Live configuration
    typedef struct packed {
        logic [SCAN_W-1:0] scan_interval;
        logic [TMR_W-1:0]  long_press;
        logic [TMR_W-1:0]  click_window;
        logic [MASK_W-1:0] active_mask;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [KEY_W-1:0] key;
        evt_code_t        code;
        logic [CNT_W-1:0] count;
        logic             last;
    } evt_t;

    // Events produced by one sample, in order
    typedef struct packed {
        logic [1:0] num;
        evt_t       ev0;
        evt_t       ev1;
    } evt_push_t;

endpackage : kclp_pkg
`default_nettype wire

// ===== rtl/kclp_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kclp_cfg_regs
// Configuration register file; takes one write per cycle.
// ----------------------------------------------------------------------------
module kclp_cfg_regs
    import kclp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write; indexes beyond the list are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCAN_INTERVAL: cfg_next.scan_interval = cfg_data[SCAN_W-1:0];
                CFG_LONG_PRESS:    cfg_next.long_press    = cfg_data[TMR_W-1:0];
                CFG_CLICK_WINDOW:  cfg_next.click_window  = cfg_data[TMR_W-1:0];
                CFG_ACTIVE_MASK:   cfg_next.active_mask   = cfg_data[MASK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_interval <= SCAN_RST;
            cfg_reg.long_press    <= LONG_RST;
            cfg_reg.click_window  <= WINDOW_RST;
            cfg_reg.active_mask   <= MASK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule : kclp_cfg_regs
`default_nettype wire

// ===== rtl/kclp_key_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kclp_key_engine
// Input register, per-key state and the combinational debounce and gesture
// update. State is written back at the edge the sample leaves the input
// register, so a following sample of the same key sees it.
// ----------------------------------------------------------------------------
module kclp_key_engine
    import kclp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [KEY_W-1:0] s_key_id,
    input  wire logic             s_raw_level,
    input  wire cfg_t             cfg,
    input  wire logic             evt_room,
    output logic                  evt_push,
    output evt_push_t             evt_data
);

    // Only keys that the key field can name need storage
    localparam int MAX_KEYS    = 1 << KEY_W;
    localparam int STORE_DEPTH = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Saturating timer advance
    function automatic logic [TMR_W-1:0] sat_add(input logic [TMR_W-1:0]  a,
                                                 input logic [SCAN_W-1:0] b);
        logic [TMR_W:0] s;
        s = {1'b0, a} + {{(TMR_W + 1 - SCAN_W){1'b0}}, b};
        return s[TMR_W] ? {TMR_W{1'b1}} : s[TMR_W-1:0];
    endfunction

    // Input register
    logic             in_valid_reg, in_valid_next;
    logic [KEY_W-1:0] key_reg;
    logic             level_reg;

    // Per-key state
    db_state_t        db_reg    [STORE_DEPTH];
    gs_state_t        gs_reg    [STORE_DEPTH];
    logic [TMR_W-1:0] hold_reg  [STORE_DEPTH];
    logic [TMR_W-1:0] gap_reg   [STORE_DEPTH];
    logic [CNT_W-1:0] click_reg [STORE_DEPTH];
    logic             lrep_reg  [STORE_DEPTH];

    logic             fire;
    logic             key_ok;
    logic [IDX_W-1:0] idx;
    logic             hit;

    db_state_t        db_next;
    gs_state_t        gs_next;
    logic [TMR_W-1:0] hold_next, gap_next, hold_inc, gap_inc;
    logic [CNT_W-1:0] click_next;
    logic             lrep_next;
    evt_code_t        click_code;

    assign fire    = in_valid_reg && evt_room;
    assign s_ready = !in_valid_reg || evt_room;
    assign key_ok  = int'(key_reg) < NUM_KEYS;
    assign idx     = key_ok ? key_reg[IDX_W-1:0] : '0;
    assign hit     = (level_reg == cfg.active_mask[key_reg]);

    assign hold_inc = sat_add(hold_reg[idx], cfg.scan_interval);
    assign gap_inc  = sat_add(gap_reg[idx], cfg.scan_interval);

    // Hold the sample until the event queue has room for two events
    assign in_valid_next = (s_valid && s_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg   <= s_key_id;
            level_reg <= s_raw_level;
        end
    end

    // Debouncer: two matching samples to change side
    always_comb begin
        unique case (db_reg[idx])
            DB_RELEASED: db_next = hit ? DB_DOWN    : DB_RELEASED;
            DB_DOWN:     db_next = hit ? DB_PRESSED : DB_RELEASED;
            DB_PRESSED:  db_next = hit ? DB_PRESSED : DB_UP;
            DB_UP:       db_next = hit ? DB_PRESSED : DB_RELEASED;
            default:     db_next = DB_RELEASED;
        endcase
    end

    // Event code from the click total
    always_comb begin
        if (click_reg[idx] == CNT_W'(1)) begin
            click_code = EV_CLICK;
        end else if (click_reg[idx] == CNT_W'(2)) begin
            click_code = EV_DOUBLE;
        end else begin
            click_code = EV_MULTI;
        end
    end

    // Gesture machine and event build
    always_comb begin
        gs_next    = gs_reg[idx];
        hold_next  = hold_reg[idx];
        gap_next   = gap_reg[idx];
        click_next = click_reg[idx];
        lrep_next  = lrep_reg[idx];
        evt_data   = '0;
        evt_data.ev0.key = key_reg;
        evt_data.ev1.key = key_reg;

        unique case (gs_reg[idx])
            GS_PRESSED: begin
                if (db_next == DB_PRESSED) begin
                    hold_next = hold_inc;
                    if (hold_inc >= cfg.long_press) begin
                        gs_next = GS_LONG;
                    end
                end else begin
                    gs_next    = GS_WAIT;
                    gap_next   = '0;
                    click_next = CNT_W'(1);
                end
            end
            GS_WAIT: begin
                gap_next = gap_inc;
                if (db_next == DB_PRESSED) begin
                    gs_next = GS_CONFIRM;
                end else if (gap_inc >= cfg.click_window) begin
                    evt_data.num       = 2'd1;
                    evt_data.ev0.code  = click_code;
                    evt_data.ev0.count = click_reg[idx];
                    evt_data.ev0.last  = 1'b1;
                    gs_next            = GS_IDLE;
                end
            end
            GS_CONFIRM: begin
                if (db_next == DB_RELEASED) begin
                    if (click_reg[idx] != {CNT_W{1'b1}}) begin
                        click_next = click_reg[idx] + CNT_W'(1);
                    end
                    gs_next  = GS_WAIT;
                    gap_next = '0;
                end
            end
            GS_LONG: begin
                // Long press first, then its release when both fall together
                if (!lrep_reg[idx] && db_next == DB_RELEASED) begin
                    evt_data.num      = 2'd2;
                    evt_data.ev0.code = EV_LONG;
                    evt_data.ev1.code = EV_LONG_REL;
                    evt_data.ev1.last = 1'b1;
                end else if (!lrep_reg[idx]) begin
                    evt_data.num      = 2'd1;
                    evt_data.ev0.code = EV_LONG;
                    evt_data.ev0.last = 1'b1;
                end else if (db_next == DB_RELEASED) begin
                    evt_data.num      = 2'd1;
                    evt_data.ev0.code = EV_LONG_REL;
                    evt_data.ev0.last = 1'b1;
                end
                lrep_next = 1'b1;
                if (db_next == DB_RELEASED) begin
                    gs_next   = GS_IDLE;
                    lrep_next = 1'b0;
                end
            end
            default: begin
                gs_next = GS_IDLE;
                if (db_next == DB_PRESSED) begin
                    gs_next    = GS_PRESSED;
                    hold_next  = '0;
                    lrep_next  = 1'b0;
                    click_next = '0;
                end
            end
        endcase

        // Drop samples of keys beyond the key count
        if (!key_ok) begin
            evt_data.num = 2'd0;
        end
    end

    assign evt_push = fire && (evt_data.num != 2'd0);

    // Write back the key's state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STORE_DEPTH; k++) begin
                db_reg[k]    <= DB_RELEASED;
                gs_reg[k]    <= GS_IDLE;
                hold_reg[k]  <= '0;
                gap_reg[k]   <= '0;
                click_reg[k] <= '0;
                lrep_reg[k]  <= 1'b0;
            end
        end else if (fire && key_ok) begin
            db_reg[idx]    <= db_next;
            gs_reg[idx]    <= gs_next;
            hold_reg[idx]  <= hold_next;
            gap_reg[idx]   <= gap_next;
            click_reg[idx] <= click_next;
            lrep_reg[idx]  <= lrep_next;
        end
    end

endmodule : kclp_key_engine
`default_nettype wire

// ===== rtl/kclp_evt_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kclp_evt_fifo
// Four-entry event queue: up to two events written per cycle, one read.
// Room is reported from registered occupancy only.
// ----------------------------------------------------------------------------
module kclp_evt_fifo
    import kclp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire evt_push_t push_data,
    output logic           room,
    output logic           m_valid,
    input  wire logic      m_ready,
    output evt_t           m_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    evt_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             pop;
    logic [PTR_W:0]   push_num;

    assign room    = count_reg <= (PTR_W + 1)'(DEPTH - 2);
    assign m_valid = count_reg != '0;
    assign m_data  = mem[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    assign push_num    = push ? (PTR_W + 1)'(push_data.num) : '0;
    assign wr_ptr_next = wr_ptr_reg + push_num[PTR_W-1:0];
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + push_num - (PTR_W + 1)'(pop);

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store events in order
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data.ev0;
            if (push_data.num == 2'd2) begin
                mem[wr_ptr_reg + PTR_W'(1)] <= push_data.ev1;
            end
        end
    end

endmodule : kclp_evt_fifo
`default_nettype wire

// ===== rtl/key_click_long_press_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_click_long_press_detector
// Per-key debounce with click, double, multi click and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_): one scan sample per transfer, key index and raw level.
//   Result channel (m_): gesture events, key, code, click count and a flag
//   on the last event caused by a sample. A sample causes zero, one or two.
//   Configuration channel (cfg_): register index and data, always ready.
//   Write it only while no sample is in flight.
// Path: a sample waits in the input register, then its events are written
//   into the result queue, which offers them. Throughput: one sample per
//   cycle while the result side keeps up; the read-modify-write of the key's
//   state as the sample leaves the input register sets this, and samples of
//   the same key may follow each other directly. A sample causing two events takes two result transfers.
// Stall: results queue in a four-entry buffer; a sample waits in the input
//   register until two entries are free, and s_ready drops behind it.
// Reset: all keys released and idle, timers and counts zero, registers at
//   their defaults, queue empty.
// ----------------------------------------------------------------------------
module key_click_long_press_detector
    import kclp_pkg::*;
#(
    parameter int NUM_KEYS = NUM_KEYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [KEY_W-1:0]      s_key_id,
    input  wire logic                  s_raw_level,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [KEY_W-1:0]           m_event_key,
    output logic [CODE_W-1:0]          m_event_code,
    output logic [CNT_W-1:0]           m_click_count,
    output logic                       m_last_event,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg;
    logic      evt_room;
    logic      evt_push;
    evt_push_t evt_data;
    evt_t      m_evt;

    kclp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kclp_key_engine #(
        .NUM_KEYS (NUM_KEYS)
    ) u_key_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_id    (s_key_id),
        .s_raw_level (s_raw_level),
        .cfg         (cfg),
        .evt_room    (evt_room),
        .evt_push    (evt_push),
        .evt_data    (evt_data)
    );

    kclp_evt_fifo u_evt_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_push),
        .push_data (evt_data),
        .room      (evt_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_evt)
    );

    assign m_event_key   = m_evt.key;
    assign m_event_code  = m_evt.code;
    assign m_click_count = m_evt.count;
    assign m_last_event  = m_evt.last;

    // A long press that is not last is always followed by its release
    a_long_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_event_code == EV_LONG && !m_last_event)
        |=> (m_valid && m_event_code == EV_LONG_REL && m_last_event))
        else $error("long press not followed by its release");

    // Long press events carry no click count
    a_long_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_code == EV_LONG || m_event_code == EV_LONG_REL))
        |-> (m_click_count == '0))
        else $error("long press event with a click count");

    // Single and double click events are always the last of their sample and agree with the count
    a_click_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_event_code == EV_CLICK || m_event_code == EV_DOUBLE))
        |-> (m_last_event && m_click_count == ((m_event_code == EV_CLICK) ?
             CNT_W'(1) : CNT_W'(2))))
        else $error("click event code and count disagree");

    // No result right after reset release
    a_reset_empty: assert property (@(posedge aclk)
        (!$past(aresetn)) |-> !m_valid)
        else $error("result offered straight after reset");

endmodule : key_click_long_press_detector
`default_nettype wire
